// ----- src/tfp_pkg.sv -----
// tfp_pkg: shared types and codes for the timed fifo port with flush
// holds the beat structs, action codes and the cell control and status structs
// no dependencies
package tfp_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH        = 3'd0,
    ACT_PUSH_LAT    = 3'd1,
    ACT_POP_HEAD    = 3'd2,
    ACT_POP_READY   = 3'd3,
    ACT_POP_EXACT   = 3'd4,
    ACT_POP_TAIL    = 3'd5,
    ACT_FLUSH       = 3'd6,
    ACT_STATS       = 3'd7
  } action_t;

  localparam logic [1:0] FILL_EMPTY = 2'd0;
  localparam logic [1:0] FILL_AVAIL = 2'd1;
  localparam logic [1:0] FILL_FULL  = 2'd2;

  localparam logic CFG_BUF_LEN    = 1'b0;
  localparam logic CFG_WIRE_DELAY = 1'b1;

  typedef struct packed {
    action_t     action;
    logic [31:0] now;
    logic [7:0]  latency;
    logic [31:0] seq_id;
    logic [31:0] payload;
  } in_beat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_seq_id;
    logic [31:0] out_payload;
    logic [3:0]  occupancy;
    logic [1:0]  fill_state;
    logic        head_ready;
    logic        head_ready_exact;
    logic        any_ready;
    logic        any_ready_exact;
    logic [3:0]  removed_count;
    logic [31:0] empty_cycles;
    logic [31:0] full_cycles;
  } out_beat_t;

  // per-cell command, at most one bit set in a cycle
  typedef struct packed {
    logic load;
    logic shift;
    logic kill;
  } cell_ctl_t;

  // per-cell compare results, all gated by valid
  typedef struct packed {
    logic valid;
    logic le;
    logic eq;
    logic ge;
  } cell_stat_t;

endpackage

// ----- src/tfp_cell.sv -----
// tfp_cell: one queue slot of the cell chain, holds seq id, payload and ready time
// loads a pushed entry, takes its upper neighbor on a shift, or drops out on a kill
// depends on tfp_pkg
module tfp_cell #(
  parameter int SEQ_BITS     = 32,
  parameter int PAYLOAD_BITS = 32,
  parameter int TIME_BITS    = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tfp_pkg::cell_ctl_t      ctl,
  input  logic [SEQ_BITS-1:0]     load_seq,
  input  logic [PAYLOAD_BITS-1:0] load_pay,
  input  logic [TIME_BITS-1:0]    load_time,
  input  logic                    nbr_valid,
  input  logic [SEQ_BITS-1:0]     nbr_seq,
  input  logic [PAYLOAD_BITS-1:0] nbr_pay,
  input  logic [TIME_BITS-1:0]    nbr_time,
  input  logic [TIME_BITS-1:0]    cmp_now,
  input  logic [SEQ_BITS-1:0]     thr,
  output logic                    valid,
  output logic [SEQ_BITS-1:0]     seq,
  output logic [PAYLOAD_BITS-1:0] pay,
  output logic [TIME_BITS-1:0]    rtime,
  output tfp_pkg::cell_stat_t     stat
);
  import tfp_pkg::*;

  logic                    valid_r, valid_nxt;
  logic [SEQ_BITS-1:0]     seq_r, seq_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [TIME_BITS-1:0]    time_r, time_nxt;

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    pay_nxt   = pay_r;
    time_nxt  = time_r;
    if (ctl.kill) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      valid_nxt = nbr_valid;
      seq_nxt   = nbr_seq;
      pay_nxt   = nbr_pay;
      time_nxt  = nbr_time;
    end else if (ctl.load) begin
      valid_nxt = 1'b1;
      seq_nxt   = load_seq;
      pay_nxt   = load_pay;
      time_nxt  = load_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    pay_r  <= pay_nxt;
    time_r <= time_nxt;
  end

  assign valid = valid_r;
  assign seq   = seq_r;
  assign pay   = pay_r;
  assign rtime = time_r;

  assign stat.valid = valid_r;
  assign stat.le    = valid_r & (time_r <= cmp_now);
  assign stat.eq    = valid_r & (time_r == cmp_now);
  assign stat.ge    = valid_r & (seq_r >= thr);

endmodule

// ----- src/timed_fifo_port_with_flush_top.sv -----
// timed_fifo_port_with_flush_top: ordered queue of timed entries with squash
// a row of tfp_cell slots plus the command sequencer and stats counters
// depends on tfp_pkg and tfp_cell
//
//   channel  ports                          handshake
//   input    start, busy, in_data           beat taken when start && !busy
//   result   out_valid, out_data            one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_idx, cfg_data      write taken when cfg_we
//
// every command has an action cycle on the cell row (a flush then walks S_FLUSH),
// then a report cycle that reads the flags of the updated row; the result strobes
// in the cycle after the report cycle, when busy is already low again
// a flush walks the tail one cell a cycle, squashing entries until the tail is below the threshold
// reset clears the slot valid bits, the fill count and the stats, and sets both config registers to 1
// the receiver cannot stall, so results never wait
module timed_fifo_port_with_flush_top #(
  parameter int DEPTH        = 8,
  parameter int TIME_BITS    = 32,
  parameter int SEQ_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tfp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  output tfp_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [7:0]         cfg_data
);
  import tfp_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_FLUSH  = 3'b010,
    S_REPORT = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [3:0]              buf_len_r;
  logic [7:0]              wire_delay_r;
  logic [31:0]             empty_cnt_r, empty_cnt_nxt;
  logic [31:0]             full_cnt_r, full_cnt_nxt;
  logic                    strobe_r, strobe_nxt;
  logic                    ok_r, ok_nxt;
  logic [SEQ_BITS-1:0]     oseq_r, oseq_nxt;
  logic [PAYLOAD_BITS-1:0] opay_r, opay_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [TIME_BITS-1:0]    now_r, now_nxt;
  logic [SEQ_BITS-1:0]     thr_r, thr_nxt;
  out_beat_t               res_r, res_nxt;

  // input fields cut or extended to the stored widths
  logic [63:0]             now64, sid64, pay64;
  logic [TIME_BITS-1:0]    in_now;
  logic [SEQ_BITS-1:0]     in_sid;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [7:0]              delay;
  logic [TIME_BITS-1:0]    push_time;
  logic [TIME_BITS-1:0]    cmp_now;

  assign now64     = 64'(in_data.now);
  assign sid64     = 64'(in_data.seq_id);
  assign pay64     = 64'(in_data.payload);
  assign in_now    = now64[TIME_BITS-1:0];
  assign in_sid    = sid64[SEQ_BITS-1:0];
  assign in_pay    = pay64[PAYLOAD_BITS-1:0];
  assign delay     = (in_data.action == ACT_PUSH) ? wire_delay_r : in_data.latency;
  assign push_time = in_now + TIME_BITS'(delay);

  // capacity clamped to 1..DEPTH
  logic [7:0]       bl8;
  logic [CNT_W-1:0] cap;
  assign bl8 = 8'(buf_len_r);
  always_comb begin
    if (bl8 == 8'd0) begin
      cap = CNT_W'(1);
    end else if (int'(bl8) > DEPTH) begin
      cap = CNT_W'(DEPTH);
    end else begin
      cap = CNT_W'(bl8);
    end
  end

  logic accept, is_push, is_pop, is_exact, is_head, is_tail_act;
  logic do_push, do_pop, do_tail, flush_kill;
  assign busy        = (state_r != S_IDLE);
  assign accept      = start & ~busy;
  assign is_push     = (in_data.action == ACT_PUSH) || (in_data.action == ACT_PUSH_LAT);
  assign is_head     = (in_data.action == ACT_POP_HEAD);
  assign is_exact    = (in_data.action == ACT_POP_EXACT);
  assign is_pop      = is_head || (in_data.action == ACT_POP_READY) || is_exact;
  assign is_tail_act = (in_data.action == ACT_POP_TAIL);

  // hits are taken against the beat's time, the report against the latched one
  assign cmp_now = (state_r == S_IDLE) ? in_now : now_r;

  // cell row wiring; index DEPTH is the empty slot past the last cell
  logic [DEPTH:0]                   c_valid;
  logic [DEPTH:0][SEQ_BITS-1:0]     c_seq;
  logic [DEPTH:0][PAYLOAD_BITS-1:0] c_pay;
  logic [DEPTH:0][TIME_BITS-1:0]    c_time;
  cell_stat_t [DEPTH-1:0]           stat;
  cell_ctl_t  [DEPTH-1:0]           ctl;
  logic [DEPTH-1:0]                 hit, first, is_tail;
  logic [DEPTH:0]                   prior;

  assign c_valid[DEPTH] = 1'b0;
  assign c_seq[DEPTH]   = '0;
  assign c_pay[DEPTH]   = '0;
  assign c_time[DEPTH]  = '0;
  assign prior[0]       = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam bit IS_FIRST = (g == 0);

    assign hit[g]     = (is_exact ? stat[g].eq : stat[g].le) & (IS_FIRST | ~is_head);
    assign prior[g+1] = prior[g] | hit[g];
    assign first[g]   = hit[g] & ~prior[g];
    assign is_tail[g] = c_valid[g] & ~c_valid[g+1];

    assign ctl[g].load  = do_push & (count_r == CNT_W'(g));
    assign ctl[g].shift = do_pop & prior[g+1];
    assign ctl[g].kill  = (do_tail | flush_kill) & is_tail[g];

    tfp_cell #(
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .TIME_BITS    (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[g]),
      .load_seq  (in_sid),
      .load_pay  (in_pay),
      .load_time (push_time),
      .nbr_valid (c_valid[g+1]),
      .nbr_seq   (c_seq[g+1]),
      .nbr_pay   (c_pay[g+1]),
      .nbr_time  (c_time[g+1]),
      .cmp_now   (cmp_now),
      .thr       (thr_r),
      .valid     (c_valid[g]),
      .seq       (c_seq[g]),
      .pay       (c_pay[g]),
      .rtime     (c_time[g]),
      .stat      (stat[g])
    );
  end

  // one-hot and-or picks of the popped and the tail entry
  logic [SEQ_BITS-1:0]     sel_seq, tail_seq;
  logic [PAYLOAD_BITS-1:0] sel_pay, tail_pay;
  logic                    tail_ge, any_le, any_eq;
  always_comb begin
    sel_seq  = '0;
    sel_pay  = '0;
    tail_seq = '0;
    tail_pay = '0;
    tail_ge  = 1'b0;
    any_le   = 1'b0;
    any_eq   = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_seq  = sel_seq  | ({SEQ_BITS{first[i]}} & c_seq[i]);
      sel_pay  = sel_pay  | ({PAYLOAD_BITS{first[i]}} & c_pay[i]);
      tail_seq = tail_seq | ({SEQ_BITS{is_tail[i]}} & c_seq[i]);
      tail_pay = tail_pay | ({PAYLOAD_BITS{is_tail[i]}} & c_pay[i]);
      tail_ge  = tail_ge  | (is_tail[i] & stat[i].ge);
      any_le   = any_le   | stat[i].le;
      any_eq   = any_eq   | stat[i].eq;
    end
  end

  assign do_push    = accept & is_push & (count_r < cap);
  assign do_pop     = accept & is_pop & prior[DEPTH];
  assign do_tail    = accept & is_tail_act & (count_r != '0);
  assign flush_kill = (state_r == S_FLUSH) & tail_ge;

  logic [63:0] oseq64, opay64, cnt64, rem64;
  assign oseq64 = 64'(oseq_r);
  assign opay64 = 64'(opay_r);
  assign cnt64  = 64'(count_r);
  assign rem64  = 64'(rem_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    empty_cnt_nxt = empty_cnt_r;
    full_cnt_nxt  = full_cnt_r;
    strobe_nxt    = 1'b0;
    ok_nxt        = ok_r;
    oseq_nxt      = oseq_r;
    opay_nxt      = opay_r;
    rem_nxt       = rem_r;
    now_nxt       = now_r;
    thr_nxt       = thr_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt   = in_now;
          thr_nxt   = in_sid;
          ok_nxt    = 1'b0;
          oseq_nxt  = '0;
          opay_nxt  = '0;
          rem_nxt   = '0;
          state_nxt = S_REPORT;
          case (in_data.action) inside
            ACT_PUSH, ACT_PUSH_LAT: begin
              if (do_push) begin
                ok_nxt    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP_HEAD, ACT_POP_READY, ACT_POP_EXACT: begin
              if (do_pop) begin
                ok_nxt    = 1'b1;
                oseq_nxt  = sel_seq;
                opay_nxt  = sel_pay;
                rem_nxt   = CNT_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_POP_TAIL: begin
              if (do_tail) begin
                ok_nxt    = 1'b1;
                oseq_nxt  = tail_seq;
                opay_nxt  = tail_pay;
                rem_nxt   = CNT_W'(1);
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_FLUSH: begin
              ok_nxt    = 1'b1;
              state_nxt = S_FLUSH;
            end
            default: begin
              ok_nxt = 1'b1;
              if (count_r == '0) begin
                if (empty_cnt_r != '1) empty_cnt_nxt = empty_cnt_r + 32'd1;
              end else if (count_r >= cap) begin
                if (full_cnt_r != '1) full_cnt_nxt = full_cnt_r + 32'd1;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        // squash one tail entry a cycle until the tail is below the threshold
        if (tail_ge) begin
          count_nxt = count_r - CNT_W'(1);
          rem_nxt   = rem_r + CNT_W'(1);
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        res_nxt.ok               = ok_r;
        res_nxt.out_seq_id       = oseq64[31:0];
        res_nxt.out_payload      = opay64[31:0];
        res_nxt.occupancy        = cnt64[3:0];
        res_nxt.fill_state       = (count_r == '0) ? FILL_EMPTY :
                                   (count_r >= cap) ? FILL_FULL : FILL_AVAIL;
        res_nxt.head_ready       = stat[0].le;
        res_nxt.head_ready_exact = stat[0].eq;
        res_nxt.any_ready        = any_le;
        res_nxt.any_ready_exact  = any_eq;
        res_nxt.removed_count    = rem64[3:0];
        res_nxt.empty_cycles     = empty_cnt_r;
        res_nxt.full_cycles      = full_cnt_r;
        strobe_nxt               = 1'b1;
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      empty_cnt_r  <= '0;
      full_cnt_r   <= '0;
      strobe_r     <= 1'b0;
      buf_len_r    <= 4'd1;
      wire_delay_r <= 8'd1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      empty_cnt_r <= empty_cnt_nxt;
      full_cnt_r  <= full_cnt_nxt;
      strobe_r    <= strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_BUF_LEN:    buf_len_r    <= cfg_data[3:0];
          CFG_WIRE_DELAY: wire_delay_r <= cfg_data;
          default:        buf_len_r    <= buf_len_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    oseq_r <= oseq_nxt;
    opay_r <= opay_nxt;
    rem_r  <= rem_nxt;
    now_r  <= now_nxt;
    thr_r  <= thr_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = strobe_r;
  assign out_data  = res_r;

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for timed_fifo_port_with_flush_top
// drives command beats and register writes, predicts every report beat and compares
// depends on tfp_pkg and the timed fifo port rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tfp_pkg::*;

  localparam int DEPTH = 8;
  localparam int RING  = 16;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  logic      cfg_we;
  logic      cfg_idx;
  logic [7:0] cfg_data;

  timed_fifo_port_with_flush_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the queue contents and registers
  logic [31:0] q_seq [DEPTH];
  logic [31:0] q_pay [DEPTH];
  logic [31:0] q_rdy [DEPTH];
  int          q_fill = 0;
  logic [31:0] cnt_empty = '0;
  logic [31:0] cnt_full = '0;
  logic [3:0]  cfg_len = 4'd1;
  logic [7:0]  cfg_wdly = 8'd1;

  // expected report beats, written by the sender and read by the monitor
  out_beat_t exp_ring [RING];
  action_t   act_ring [RING];
  int        wr_cnt = 0;
  int        rd_cnt = 0;

  int mismatches = 0;
  int results_checked = 0;
  int items_sent = 0;
  int settings_used = 0;
  int pops_hit = 0;
  int squashed = 0;
  bit idle_on = 1'b1;

  logic [31:0] cur_now = '0;
  logic [31:0] next_seq = '0;

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string tag, string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s %s got %0h want %0h", tag, name, got, want));
  endtask

  function automatic out_beat_t port_result(in_beat_t b);
    out_beat_t  r;
    int         lim;
    int         pick;
    logic [7:0] dly;
    r = '0;
    lim = (cfg_len == 4'd0) ? 1 : ((int'(cfg_len) > DEPTH) ? DEPTH : int'(cfg_len));
    case (b.action) inside
      ACT_PUSH, ACT_PUSH_LAT: begin
        if (q_fill < lim) begin
          dly = (b.action == ACT_PUSH) ? cfg_wdly : b.latency;
          q_seq[q_fill] = b.seq_id;
          q_pay[q_fill] = b.payload;
          q_rdy[q_fill] = b.now + 32'(dly);
          q_fill++;
          r.ok = 1'b1;
        end
      end
      ACT_POP_HEAD, ACT_POP_READY, ACT_POP_EXACT: begin
        pick = -1;
        for (int i = 0; i < q_fill; i++) begin
          if (pick < 0 && (b.action != ACT_POP_HEAD || i == 0)) begin
            if ((b.action == ACT_POP_EXACT) ? (q_rdy[i] == b.now) : (q_rdy[i] <= b.now))
              pick = i;
          end
        end
        if (pick >= 0) begin
          r.ok = 1'b1;
          r.out_seq_id = q_seq[pick];
          r.out_payload = q_pay[pick];
          r.removed_count = 4'd1;
          for (int i = pick; i < q_fill - 1; i++) begin
            q_seq[i] = q_seq[i + 1];
            q_pay[i] = q_pay[i + 1];
            q_rdy[i] = q_rdy[i + 1];
          end
          q_fill--;
        end
      end
      ACT_POP_TAIL: begin
        if (q_fill > 0) begin
          r.ok = 1'b1;
          r.out_seq_id = q_seq[q_fill - 1];
          r.out_payload = q_pay[q_fill - 1];
          r.removed_count = 4'd1;
          q_fill--;
        end
      end
      ACT_FLUSH: begin
        // squash younger entries from the tail down to the threshold
        while (q_fill > 0 && q_seq[q_fill - 1] >= b.seq_id) begin
          q_fill--;
          r.removed_count++;
        end
        r.ok = 1'b1;
      end
      default: begin
        if (q_fill == 0) begin
          if (cnt_empty != 32'hFFFF_FFFF) cnt_empty++;
        end else if (q_fill >= lim) begin
          if (cnt_full != 32'hFFFF_FFFF) cnt_full++;
        end
        r.ok = 1'b1;
      end
    endcase
    for (int i = 0; i < q_fill; i++) begin
      if (q_rdy[i] <= b.now) begin
        r.any_ready = 1'b1;
        if (i == 0) r.head_ready = 1'b1;
      end
      if (q_rdy[i] == b.now) begin
        r.any_ready_exact = 1'b1;
        if (i == 0) r.head_ready_exact = 1'b1;
      end
    end
    r.occupancy = 4'(q_fill);
    if (q_fill == 0) r.fill_state = FILL_EMPTY;
    else if (q_fill >= lim) r.fill_state = FILL_FULL;
    else r.fill_state = FILL_AVAIL;
    r.empty_cycles = cnt_empty;
    r.full_cycles = cnt_full;
    return r;
  endfunction

  always @(posedge clk) begin : report_monitor
    out_beat_t want;
    action_t   act;
    string     tag;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (rd_cnt == wr_cnt) begin
        report_mismatch("report beat with nothing outstanding");
      end else begin
        want = exp_ring[rd_cnt % RING];
        act = act_ring[rd_cnt % RING];
        rd_cnt++;
        tag = $sformatf("beat %0d (%s)", results_checked, act.name());
        check_field(tag, "ok", 32'(out_data.ok), 32'(want.ok));
        check_field(tag, "out_seq_id", out_data.out_seq_id, want.out_seq_id);
        check_field(tag, "out_payload", out_data.out_payload, want.out_payload);
        check_field(tag, "occupancy", 32'(out_data.occupancy), 32'(want.occupancy));
        check_field(tag, "fill_state", 32'(out_data.fill_state), 32'(want.fill_state));
        check_field(tag, "head_ready", 32'(out_data.head_ready), 32'(want.head_ready));
        check_field(tag, "head_ready_exact", 32'(out_data.head_ready_exact),
                    32'(want.head_ready_exact));
        check_field(tag, "any_ready", 32'(out_data.any_ready), 32'(want.any_ready));
        check_field(tag, "any_ready_exact", 32'(out_data.any_ready_exact),
                    32'(want.any_ready_exact));
        check_field(tag, "removed_count", 32'(out_data.removed_count),
                    32'(want.removed_count));
        check_field(tag, "empty_cycles", out_data.empty_cycles, want.empty_cycles);
        check_field(tag, "full_cycles", out_data.full_cycles, want.full_cycles);
        results_checked++;
      end
    end
  end

  task automatic send_beat(in_beat_t b);
    int        gap;
    out_beat_t r;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      @(negedge clk) start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= b;
    // busy only moves at the rising edge, so it is stable here
    while (busy) @(negedge clk);
    @(posedge clk);
    r = port_result(b);
    if (r.removed_count != 4'd0) begin
      if (b.action == ACT_FLUSH) squashed += int'(r.removed_count);
      else pops_hit++;
    end
    exp_ring[wr_cnt % RING] = r;
    act_ring[wr_cnt % RING] = b.action;
    wr_cnt++;
    items_sent++;
  endtask

  task automatic drain_results(int settle);
    int waited;
    @(negedge clk) start <= 1'b0;
    waited = 0;
    while ((wr_cnt - rd_cnt) != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if ((wr_cnt - rd_cnt) != 0) report_mismatch("report beats missing after drain");
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    drain_results(4);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == CFG_BUF_LEN) cfg_len = val[3:0];
    else cfg_wdly = val;
    settings_used++;
  endtask

  function automatic in_beat_t mk_beat(action_t a, logic [31:0] t, logic [7:0] lat,
                                       logic [31:0] sid, logic [31:0] pay);
    in_beat_t b;
    b.action = a;
    b.now = t;
    b.latency = lat;
    b.seq_id = sid;
    b.payload = pay;
    return b;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) b.action = ACT_PUSH;
    else if (roll < 40) b.action = ACT_PUSH_LAT;
    else if (roll < 52) b.action = ACT_POP_HEAD;
    else if (roll < 64) b.action = ACT_POP_READY;
    else if (roll < 74) b.action = ACT_POP_EXACT;
    else if (roll < 82) b.action = ACT_POP_TAIL;
    else if (roll < 90) b.action = ACT_FLUSH;
    else b.action = ACT_STATS;
    // time mostly creeps forward, with rare jumps, wrap approaches and stray values
    roll = $urandom_range(0, 99);
    if (roll < 2) cur_now = $urandom;
    else if (roll < 3) cur_now = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    else if (roll >= 5) cur_now = cur_now + 32'($urandom_range(0, 3));
    b.now = (roll >= 3 && roll < 5) ? $urandom : cur_now;
    b.latency = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 6));
    b.payload = $urandom;
    if (b.action == ACT_PUSH || b.action == ACT_PUSH_LAT) begin
      if ($urandom_range(0, 9) == 0) begin
        b.seq_id = $urandom;
      end else begin
        b.seq_id = next_seq;
        next_seq++;
      end
    end else if (b.action == ACT_FLUSH) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        b.seq_id = next_seq - 32'($urandom_range(0, 8));
        next_seq = b.seq_id;
      end else if (roll < 75) begin
        b.seq_id = '0;
      end else if (roll < 85) begin
        b.seq_id = 32'hFFFF_FFFF;
      end else begin
        b.seq_id = $urandom;
      end
    end else begin
      b.seq_id = $urandom;
    end
    return b;
  endfunction

  task automatic test_empty_queue();
    send_beat(mk_beat(ACT_STATS, 32'd100, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_HEAD, 32'd100, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_READY, 32'd100, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_EXACT, 32'd100, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_TAIL, 32'd100, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_FLUSH, 32'd100, 8'd1, 32'd0, 32'd0));
  endtask

  task automatic test_push_and_pops();
    // length above depth is clamped to depth
    write_reg(CFG_BUF_LEN, 8'd15);
    write_reg(CFG_WIRE_DELAY, 8'd2);
    send_beat(mk_beat(ACT_PUSH, 32'd200, 8'd9, 32'd10, 32'hA5A5_0010));
    send_beat(mk_beat(ACT_PUSH, 32'd200, 8'd9, 32'd11, 32'hA5A5_0011));
    send_beat(mk_beat(ACT_PUSH_LAT, 32'd200, 8'd255, 32'd12, 32'hA5A5_0012));
    send_beat(mk_beat(ACT_PUSH_LAT, 32'd200, 8'd0, 32'd13, 32'hA5A5_0013));
    send_beat(mk_beat(ACT_POP_HEAD, 32'd200, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_EXACT, 32'd200, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_READY, 32'd202, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_POP_TAIL, 32'd202, 8'd1, 32'd0, 32'd0));
  endtask

  task automatic test_capacity();
    // length 0 acts as 1, so the one held entry already fills the queue
    write_reg(CFG_BUF_LEN, 8'd0);
    send_beat(mk_beat(ACT_STATS, 32'd210, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_PUSH, 32'd210, 8'd1, 32'd14, 32'hA5A5_0014));
  endtask

  task automatic test_wrap_and_flush();
    write_reg(CFG_BUF_LEN, 8'd8);
    write_reg(CFG_WIRE_DELAY, 8'd255);
    // ready time wraps past zero and counts as already reached
    send_beat(mk_beat(ACT_PUSH, 32'hFFFF_FF80, 8'd1, 32'hFFFF_FFFF, 32'h0));
    send_beat(mk_beat(ACT_PUSH_LAT, 32'hFFFF_FFFF, 8'd0, 32'h0, 32'hFFFF_FFFF));
    send_beat(mk_beat(ACT_POP_EXACT, 32'hFFFF_FFFF, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_FLUSH, 32'hFFFF_FFFF, 8'd1, 32'd12, 32'd0));
    write_reg(CFG_WIRE_DELAY, 8'd0);
    send_beat(mk_beat(ACT_PUSH, 32'd0, 8'd1, 32'd30, 32'hA5A5_0030));
    send_beat(mk_beat(ACT_POP_EXACT, 32'd0, 8'd1, 32'd0, 32'd0));
    send_beat(mk_beat(ACT_FLUSH, 32'd0, 8'd1, 32'd0, 32'd0));
  endtask

  task automatic test_random_traffic();
    logic [3:0] lens [8]  = '{4'd8, 4'd1, 4'd4, 4'd15, 4'd0, 4'd8, 4'd3, 4'd8};
    logic [7:0] delays [8] = '{8'd1, 8'd2, 8'd0, 8'd3, 8'd1, 8'd255, 8'd5, 8'd2};
    cur_now = $urandom;
    next_seq = $urandom;
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_BUF_LEN, {4'd0, lens[p]});
      write_reg(CFG_WIRE_DELAY, delays[p]);
      for (int n = 0; n < 200; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_beat(random_beat());
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_empty_queue();
    test_push_and_pops();
    test_capacity();
    test_wrap_and_flush();
    test_random_traffic();

    drain_results(16);
    if ((wr_cnt - rd_cnt) != 0) report_mismatch("report beats never arrived");
    $display("sent %0d command beats across %0d register writes, checked %0d reports",
             items_sent, settings_used, results_checked);
    $display("pops that found an entry: %0d, entries squashed by flush: %0d, mismatches: %0d",
             pops_hit, squashed, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for the port");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
